[design/irds_pkg.sv]
// Shared types, constants and the digit-to-character map for the radix converter.
package irds_pkg;

    localparam int RADIX_W    = 6;
    localparam int CHAR_W     = 8;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd62;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd4;
    localparam logic               NUC_RESET   = 1'b1;

    // register index, taken from paddr[2]
    localparam logic REG_RADIX = 1'b0;
    localparam logic REG_NUC   = 1'b1;

    localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;  // '0'
    localparam logic [CHAR_W-1:0] CHAR_UPPER = 8'h41;  // 'A'
    localparam logic [CHAR_W-1:0] CHAR_LOWER = 8'h61;  // 'a'
    localparam logic [CHAR_W-1:0] CHAR_NUC_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_NUC_C = 8'h43;
    localparam logic [CHAR_W-1:0] CHAR_NUC_G = 8'h47;
    localparam logic [CHAR_W-1:0] CHAR_NUC_T = 8'h54;

    localparam logic [RADIX_W-1:0] DIGIT_NUC_END = 6'd4;
    localparam logic [RADIX_W-1:0] DIGIT_DEC_END = 6'd10;
    localparam logic [RADIX_W-1:0] DIGIT_UP_END  = 6'd36;

    typedef struct packed {
        logic [RADIX_W-1:0] radix;
        logic               nuc;
        logic               err;
    } t_job_ctl;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d,
                                                     input logic nuc);
        logic [CHAR_W-1:0] dx;
        dx = {{(CHAR_W-RADIX_W){1'b0}}, d};
        if (nuc && d < DIGIT_NUC_END) begin
            unique case (d[1:0])
                2'd0: digit_char = CHAR_NUC_A;
                2'd1: digit_char = CHAR_NUC_C;
                2'd2: digit_char = CHAR_NUC_G;
                default: digit_char = CHAR_NUC_T;
            endcase
        end else if (d < DIGIT_DEC_END) begin
            digit_char = CHAR_ZERO + dx;
        end else if (d < DIGIT_UP_END) begin
            digit_char = CHAR_UPPER + dx - {{(CHAR_W-RADIX_W){1'b0}}, DIGIT_DEC_END};
        end else begin
            digit_char = CHAR_LOWER + dx - {{(CHAR_W-RADIX_W){1'b0}}, DIGIT_UP_END};
        end
    endfunction

endpackage

[design/irds_front.sv]
// Front end: configuration registers, item acceptance and radix check.
module irds_front #(
    parameter int VALUE_BITS = 31
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [irds_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [irds_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [irds_pkg::APB_DATA_W-1:0]   prdata,
    input  logic                              start,
    input  logic                              i_full,
    input  logic [VALUE_BITS-1:0]             i_value,
    output logic                              o_push,
    output irds_pkg::t_job_ctl                o_ctl,
    output logic [VALUE_BITS-1:0]             o_value
);
    import irds_pkg::*;

    logic [RADIX_W-1:0] r_radix;
    logic               r_nuc;
    logic               wr_en;

    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RESET;
            r_nuc   <= NUC_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_RADIX: r_radix <= pwdata[RADIX_W-1:0];
                default:   r_nuc   <= pwdata[0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_RADIX: prdata = {{(APB_DATA_W-RADIX_W){1'b0}}, r_radix};
            default:   prdata = {{(APB_DATA_W-1){1'b0}}, r_nuc};
        endcase
    end

    assign o_push    = start && !i_full;
    assign o_ctl.radix = r_radix;
    assign o_ctl.nuc   = r_nuc;
    assign o_ctl.err   = (r_radix < RADIX_MIN) || (r_radix > RADIX_MAX);
    assign o_value   = i_value;

endmodule

[design/irds_queue.sv]
// Two-entry queue between the front end and the conversion engine.
module irds_queue #(
    parameter int DATA_W = 39
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_full,
    output logic              o_empty
);
    logic [DATA_W-1:0] r_mem [2];
    logic              r_wptr;
    logic              r_rptr;
    logic [1:0]        r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_data  = r_mem[r_rptr];
    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);

endmodule

[design/irds_back.sv]
// Conversion engine: bit-serial division per digit, digit stack, MSB-first emission.
module irds_back #(
    parameter int VALUE_BITS = 31
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_empty,
    input  irds_pkg::t_job_ctl          i_ctl,
    input  logic [VALUE_BITS-1:0]       i_value,
    output logic                        o_pop,
    output logic                        o_strobe,
    output logic [irds_pkg::CHAR_W-1:0] o_char_code,
    output logic                        o_last,
    output logic                        o_error
);
    import irds_pkg::*;

    localparam int CNT_W = $clog2(VALUE_BITS + 1);
    localparam int IDX_W = $clog2(VALUE_BITS);

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_RD, S_OUT} t_state;

    t_state              r_state;
    logic [VALUE_BITS-1:0] r_quo;
    logic [RADIX_W-1:0]  r_rem;
    logic [RADIX_W-1:0]  r_radix;
    logic                r_nuc;
    logic [IDX_W-1:0]    r_step;
    logic [CNT_W-1:0]    r_ndig;
    logic                r_strobe;
    logic [CHAR_W-1:0]   r_char;
    logic                r_last;
    logic                r_error;

    logic [RADIX_W-1:0]  r_dig_mem [VALUE_BITS];
    logic [RADIX_W-1:0]  r_rd_data;

    logic [RADIX_W:0]      shifted;
    logic                  ge;
    logic [RADIX_W:0]      diff;
    logic [RADIX_W-1:0]    n_rem;
    logic [VALUE_BITS-1:0] n_quo;
    logic                  last_step;
    logic                  mem_we;
    logic [IDX_W-1:0]      rd_addr;
    logic [CNT_W-1:0]      ndig_dec;

    // one restoring division step: remainder stays below the radix
    always_comb begin
        shifted   = {r_rem, r_quo[VALUE_BITS-1]};
        ge        = shifted >= {1'b0, r_radix};
        diff      = shifted - {1'b0, r_radix};
        n_rem     = ge ? diff[RADIX_W-1:0] : shifted[RADIX_W-1:0];
        n_quo     = {r_quo[VALUE_BITS-2:0], ge};
        last_step = (r_step == IDX_W'(VALUE_BITS - 1));
        mem_we    = (r_state == S_DIV) && last_step;
        ndig_dec  = r_ndig - CNT_W'(1);
        rd_addr   = ndig_dec[IDX_W-1:0];
    end

    assign o_pop = (r_state == S_IDLE) && !i_empty;

    // digits are written least significant first and read back from the top
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_dig_mem[r_ndig[IDX_W-1:0]] <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_dig_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_quo   <= i_value;
                        r_radix <= i_ctl.radix;
                        r_nuc   <= i_ctl.nuc;
                        r_rem   <= '0;
                        r_step  <= '0;
                        r_ndig  <= '0;
                        if (i_ctl.err) begin
                            r_strobe <= 1'b1;
                            r_char   <= CHAR_NONE;
                            r_last   <= 1'b1;
                            r_error  <= 1'b1;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_quo <= n_quo;
                    if (last_step) begin
                        r_ndig <= r_ndig + CNT_W'(1);
                        r_rem  <= '0;
                        r_step <= '0;
                        if (n_quo == '0) begin
                            r_state <= S_RD;
                        end
                    end else begin
                        r_rem  <= n_rem;
                        r_step <= r_step + IDX_W'(1);
                    end
                end
                S_RD: begin
                    r_state <= S_OUT;
                end
                default: begin
                    r_strobe <= 1'b1;
                    r_char   <= digit_char(r_rd_data, r_nuc);
                    r_last   <= (r_ndig == CNT_W'(1));
                    r_error  <= 1'b0;
                    r_ndig   <= ndig_dec;
                    r_state  <= (r_ndig == CNT_W'(1)) ? S_IDLE : S_RD;
                end
            endcase
        end
    end

    assign o_strobe    = r_strobe;
    assign o_char_code = r_char;
    assign o_last      = r_last;
    assign o_error     = r_error;

endmodule

[design/integer_to_radix_digit_string.sv]
// Top level: integer to radix digit string converter, front end, queue and engine.
// Engine per item of n digits: one bit-serial division per digit, then each character is read
// from the digit stack in S_RD and emitted in S_OUT; the engine takes a new item only when idle.
// With an idle engine the first character follows all divisions of the item, S_RD and S_OUT;
// an invalid radix gives its lone error result straight from S_IDLE, registered. Two items queue up.
// Sync active-low reset: radix 4, letter mode on, queue empty. Results are never stalled.
module integer_to_radix_digit_string #(
    parameter int VALUE_BITS = 31
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [irds_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [irds_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [irds_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    input  logic                              start,
    output logic                              busy,
    input  logic [VALUE_BITS-1:0]             i_value,
    output logic                              o_strobe,
    output logic [irds_pkg::CHAR_W-1:0]       o_char_code,
    output logic                              o_last,
    output logic                              o_error
);
    import irds_pkg::*;

    localparam int Q_W = $bits(t_job_ctl) + VALUE_BITS;

    logic                  q_push;
    logic                  q_pop;
    logic                  q_full;
    logic                  q_empty;
    t_job_ctl              f_ctl;
    logic [VALUE_BITS-1:0] f_value;
    logic [Q_W-1:0]        q_rdata;
    t_job_ctl              b_ctl;
    logic [VALUE_BITS-1:0] b_value;

    assign pready = 1'b1;
    assign busy   = q_full;

    irds_front #(.VALUE_BITS(VALUE_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .start   (start),
        .i_full  (q_full),
        .i_value (i_value),
        .o_push  (q_push),
        .o_ctl   (f_ctl),
        .o_value (f_value)
    );

    irds_queue #(.DATA_W(Q_W)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  ({f_ctl, f_value}),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    assign {b_ctl, b_value} = q_rdata;

    irds_back #(.VALUE_BITS(VALUE_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .i_ctl       (b_ctl),
        .i_value     (b_value),
        .o_pop       (q_pop),
        .o_strobe    (o_strobe),
        .o_char_code (o_char_code),
        .o_last      (o_last),
        .o_error     (o_error)
    );

    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_error |-> o_last && (o_char_code == CHAR_NONE))
        else $error("error result not a lone last item");

    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_error |->
            (o_char_code >= 8'h30 && o_char_code <= 8'h39) ||
            (o_char_code >= 8'h41 && o_char_code <= 8'h5a) ||
            (o_char_code >= 8'h61 && o_char_code <= 8'h7a))
        else $error("digit character outside 0-9, A-Z, a-z");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("engine popped an empty queue");

endmodule

[tb/irds_checker.sv]
// Checker for the radix converter: predicts the character stream of every item and compares it.
module irds_checker #(
    parameter int VALUE_BITS = 31
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic                            pready,
    input  logic [irds_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [irds_pkg::APB_DATA_W-1:0] pwdata,
    input  logic                            start,
    input  logic                            busy,
    input  logic [VALUE_BITS-1:0]           i_value,
    input  logic                            o_strobe,
    input  logic [irds_pkg::CHAR_W-1:0]     o_char_code,
    input  logic                            o_last,
    input  logic                            o_error,
    output int                              fail_count,
    output int                              pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import irds_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
        logic              err;
    } t_char_rec;

    t_char_rec          expected_chars[$];
    logic [RADIX_W-1:0] cur_radix;
    logic               cur_nuc;
    int                 fails = 0;

    initial begin
        fail_count    = 0;
        pending_count = 0;
    end

    function automatic logic [CHAR_W-1:0] symbol_for_digit(input int unsigned d,
                                                           input logic nuc);
        if (nuc && d < DIGIT_NUC_END) begin
            case (d)
                0: return CHAR_NUC_A;
                1: return CHAR_NUC_C;
                2: return CHAR_NUC_G;
                default: return CHAR_NUC_T;
            endcase
        end
        if (d < DIGIT_DEC_END)
            return CHAR_ZERO + CHAR_W'(d);
        if (d < DIGIT_UP_END)
            return CHAR_UPPER + CHAR_W'(d - DIGIT_DEC_END);
        return CHAR_LOWER + CHAR_W'(d - DIGIT_UP_END);
    endfunction

    // Queue the characters one item should produce under the current setting.
    function automatic void expand_to_digits(input logic [VALUE_BITS-1:0] value);
        longint unsigned v;
        int unsigned     digs[64];
        int              n;
        t_char_rec       rec;
        if (cur_radix < RADIX_MIN || cur_radix > RADIX_MAX) begin
            rec.code = CHAR_NONE;
            rec.last = 1'b1;
            rec.err  = 1'b1;
            expected_chars.push_back(rec);
            return;
        end
        v = value;
        n = 0;
        do begin
            digs[n] = 32'(v % cur_radix);
            v       = v / cur_radix;
            n++;
        end while (v != 0);
        for (int k = 0; k < n; k++) begin
            rec.code = symbol_for_digit(digs[n-1-k], cur_nuc);
            rec.last = (k == n - 1);
            rec.err  = 1'b0;
            expected_chars.push_back(rec);
        end
    endfunction

    always @(posedge i_clk) begin
        t_char_rec want;
        if (!i_rst_n) begin
            cur_radix = RADIX_RESET;
            cur_nuc   = NUC_RESET;
            expected_chars.delete();
        end else begin
            if (o_strobe) begin
                if (expected_chars.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result, expected none, actual char=%h last=%b error=%b",
                             $time, o_char_code, o_last, o_error);
                end else begin
                    want = expected_chars.pop_front();
                    if (want.code !== o_char_code || want.last !== o_last ||
                        want.err !== o_error) begin
                        fails++;
                        $display("%0t: mismatch, expected char=%h last=%b error=%b, %s",
                                 $time, want.code, want.last, want.err,
                                 $sformatf("actual char=%h last=%b error=%b",
                                           o_char_code, o_last, o_error));
                    end
                end
            end
            // item uses the setting in force before any write on this edge
            if (start && !busy)
                expand_to_digits(i_value);
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_RADIX)
                    cur_radix = pwdata[RADIX_W-1:0];
                else
                    cur_nuc = pwdata[0];
            end
        end
        fail_count    <= fails;
        pending_count <= expected_chars.size();
    end

endmodule

[tb/integer_to_radix_digit_string_test.sv]
// Testbench top for the radix converter: clock, reset, register writes and item stimulus.
module integer_to_radix_digit_string_test;
    timeunit 1ns;
    timeprecision 1ps;

    import irds_pkg::*;

    localparam int VALUE_BITS  = 31;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int TAIL_CYCLES = 40;
    localparam int RAND_ITEMS  = 58;  // per idling phase

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  start   = 1'b0;
    logic                  busy;
    logic [VALUE_BITS-1:0] i_value = '0;
    logic                  o_strobe;
    logic [CHAR_W-1:0]     o_char_code;
    logic                  o_last;
    logic                  o_error;
    int                    fail_count;
    int                    pending_count;
    int                    cycle_count = 0;

    always #10 i_clk = ~i_clk;

    integer_to_radix_digit_string #(
        .VALUE_BITS(VALUE_BITS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .start      (start),
        .busy       (busy),
        .i_value    (i_value),
        .o_strobe   (o_strobe),
        .o_char_code(o_char_code),
        .o_last     (o_last),
        .o_error    (o_error)
    );

    irds_checker #(
        .VALUE_BITS(VALUE_BITS)
    ) i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .start        (start),
        .busy         (busy),
        .i_value      (i_value),
        .o_strobe     (o_strobe),
        .o_char_code  (o_char_code),
        .o_last       (o_last),
        .o_error      (o_error),
        .fail_count   (fail_count),
        .pending_count(pending_count)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Setup then access phase; the bus then goes quiet so writes never overlap.
    task automatic write_reg(input logic idx, input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Junk in the upper data bits must be dropped by the block.
    task automatic set_config(input logic [RADIX_W-1:0] radix, input logic nuc);
        write_reg(REG_RADIX, ($urandom() & ~32'h3F) | APB_DATA_W'(radix));
        write_reg(REG_NUC, ($urandom() & ~32'h1) | APB_DATA_W'(nuc));
    endtask

    // Leaves start high after acceptance so back-to-back items stay possible.
    task automatic convert(input logic [VALUE_BITS-1:0] value, input int idle_pct);
        int gap;
        if ($urandom_range(0, 99) < idle_pct) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 60) : $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start   <= 1'b1;
        i_value <= value;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
    endtask

    function automatic logic [VALUE_BITS-1:0] rand_value();
        int                    len;
        logic [VALUE_BITS-1:0] mask;
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: begin
                len  = $urandom_range(1, VALUE_BITS);
                mask = ({{(VALUE_BITS-1){1'b0}}, 1'b1} << len) - 1'b1;
                return VALUE_BITS'({$urandom(), $urandom()}) & mask;
            end
        endcase
    endfunction

    function automatic logic [RADIX_W-1:0] rand_radix();
        case ($urandom_range(0, 11))
            0: return RADIX_MIN;
            1: return RADIX_MAX;
            2: return 6'd0;
            3: return 6'd1;
            4: return 6'h3F;
            default: return RADIX_W'($urandom_range(2, 62));
        endcase
    endfunction

    initial begin
        int idle_pct;
        int sent;
        int batch;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset setting first (base 4, letters on)
        convert('0, 20);
        convert(VALUE_BITS'(27), 20);
        convert('1, 20);
        drain();
        set_config(RADIX_MIN, 1'b0);
        convert('0, 20);
        convert('1, 20);
        convert(VALUE_BITS'(1), 20);
        drain();
        set_config(RADIX_MAX, 1'b0);
        convert(VALUE_BITS'(61), 20);
        convert(VALUE_BITS'(10), 20);
        convert(VALUE_BITS'(36), 20);
        convert(VALUE_BITS'(62), 20);
        convert('1, 20);
        drain();
        // letters on above base 10: digit 0 and digit 10 both print as 'A'
        set_config(RADIX_MAX, 1'b1);
        convert(VALUE_BITS'(10), 20);
        convert('0, 20);
        convert(VALUE_BITS'(3), 20);
        drain();
        set_config(6'd10, 1'b0);
        convert(VALUE_BITS'(1234567890), 20);
        drain();
        set_config(6'd36, 1'b1);
        convert(VALUE_BITS'(35), 20);
        convert(VALUE_BITS'(4), 20);
        drain();
        // bad bases give a lone error result
        set_config(6'd0, 1'b0);
        convert(VALUE_BITS'(5), 20);
        drain();
        set_config(6'd1, 1'b1);
        convert('0, 20);
        drain();
        set_config(6'h3F, 1'b0);
        convert('1, 20);
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            idle_pct = (ph == 0) ? 20 : (ph == 1) ? 48 : 0;
            sent = 0;
            while (sent < RAND_ITEMS) begin
                set_config(rand_radix(), 1'($urandom_range(0, 1)));
                batch = $urandom_range(4, 14);
                repeat (batch) convert(rand_value(), idle_pct);
                sent += batch;
                drain();
            end
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
